>>> src/bfau_pkg.sv
`timescale 1ns / 1ps

package bfau_pkg;

	// field and item widths
	localparam int ELEM_W     = 32;
	localparam int DEG_W      = 6;
	localparam int MIDX_W     = 5;                    // holds m-1
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// largest supported degree, capped at the element width
	localparam int MAX_DEGREE = 32;
	localparam logic [DEG_W-1:0] DEG_CAP =
		DEG_W'((MAX_DEGREE > ELEM_W) ? ELEM_W : MAX_DEGREE);

	// multiplier digit: bits of the second operand consumed per cycle
	localparam int DIGIT_W    = 8;
	localparam int DIGIT_SH   = $clog2(DIGIT_W);
	localparam int NUM_DIGITS = ELEM_W / DIGIT_W;
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

	// register reset values: x^8 + x^4 + x^3 + x^2 + 1
	localparam logic [DEG_W-1:0]  DEGREE_RESET = 6'd8;
	localparam logic [ELEM_W-1:0] POLY_RESET   = 32'd29;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INV = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_DEGREE   = 1'b0,
		REG_REDUCTION_POLY = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOOP_SQ,
		ST_LOOP_MG,
		ST_LAST_SQ,
		ST_FIN_MUL,
		ST_WRITE
	} state_t;

	// source of the working register
	typedef enum logic [2:0] {
		T_HOLD,
		T_XOR,
		T_ZERO,
		T_BASE,
		T_B,
		T_PROD
	} t_src_t;

	// multiplier operand pairs: t*t, t*g, a*t
	typedef enum logic [1:0] {
		MS_TT,
		MS_TG,
		MS_AT
	} mul_src_t;

	typedef struct packed {
		logic     load;
		t_src_t   t_src;
		logic     g_load;
		logic     base_b;
		logic     mul_go;
		mul_src_t mul_src;
		logic     out_load;
		logic     out_err;
	} dp_cmd_t;

	typedef struct packed {
		logic             a_zero;
		logic             b_zero;
		logic             mul_done;
		logic [DEG_W-1:0] degree;
	} dp_sts_t;

endpackage

>>> src/binary_field_arithmetic_unit.sv
`timescale 1ns / 1ps

// GF(2^m) arithmetic unit, polynomial basis, m = 1..32.
// Input stream (s_*): one beat per operation; s_tuser carries the op code
// (add, sub, multiply, divide, inverse), s_tdata the two operands.
// Output stream (m_*): one beat per input beat, in order; m_tdata is the
// result, m_tuser flags a zero divisor (result then 0).
// Config: cfg_we/cfg_index/cfg_data, write only while no beat is in flight.
// Index 0 is the field degree m (clamped to 1..32), index 1 the low
// coefficients of the modulus (x^m term implicit).
// Rate: one item at a time. Each product passes through the digit-serial
// multiplier, which takes 8 bits of the second operand per cycle, ceil(m/8) digits
// in all. Steps from the accepting edge until m_tvalid rises:
//   add/sub/unused op: decode, write
//   multiply:          decode, one product, write
//   inverse:           decode, 2m-3 products (one at m = 1), write
//   divide:            as inverse, then one more product before write
// A new beat can be taken in the cycle after the previous result is loaded into the
// output register; that register holds while m_tready is low, and the unit
// waits for it to empty before loading the next result.
// Reset: degree 8, modulus x^8+x^4+x^3+x^2+1, both streams idle.
module binary_field_arithmetic_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [bfau_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bfau_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [2*bfau_pkg::ELEM_W-1:0]        s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  logic [bfau_pkg::OP_W-1:0]            s_tuser,   // [2:0] operation
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bfau_pkg::ELEM_W-1:0]          m_tdata,   // [31:0] result_value
	output logic                                 m_tuser    // [0] zero_divisor_error
);

	bfau_pkg::dp_cmd_t cmd;
	bfau_pkg::dp_sts_t sts;

	// sequencing: decode, exponent loop, output handshake
	bfau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op_in    (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// operands, working value, multiplier and output register
	bfau_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_a      (s_tdata[bfau_pkg::ELEM_W-1:0]),
		.in_b      (s_tdata[2*bfau_pkg::ELEM_W-1:bfau_pkg::ELEM_W]),
		.cmd       (cmd),
		.sts       (sts),
		.out_value (m_tdata),
		.out_err   (m_tuser)
	);

endmodule

>>> src/bfau_mul.sv
`timescale 1ns / 1ps

// Digit-serial GF(2^m) multiplier, MSB-first interleaved reduction.
module bfau_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [bfau_pkg::ELEM_W-1:0]         x,
	input  logic [bfau_pkg::ELEM_W-1:0]         y,
	input  logic [bfau_pkg::ELEM_W-1:0]         mask,
	input  logic [bfau_pkg::ELEM_W-1:0]         poly,
	input  logic [bfau_pkg::MIDX_W-1:0]         mtop,
	output logic                                done,
	output logic [bfau_pkg::ELEM_W-1:0]         prod
);

	logic                              busy_q;
	logic [bfau_pkg::DIG_IDX_W-1:0]    dig_q;
	logic [bfau_pkg::ELEM_W-1:0]       x_q;
	logic [bfau_pkg::ELEM_W-1:0]       y_q;
	logic [bfau_pkg::ELEM_W-1:0]       acc_q;
	logic [bfau_pkg::ELEM_W-1:0]       acc;
	logic [bfau_pkg::DIGIT_W-1:0]      digit;
	logic                              top;

	// one digit of y per cycle: shift, reduce on overflow of x^(m-1), add x
	always_comb begin
		acc   = acc_q;
		top   = 1'b0;
		digit = y_q[dig_q * bfau_pkg::DIGIT_W +: bfau_pkg::DIGIT_W];
		for (int j = bfau_pkg::DIGIT_W - 1; j >= 0; j--) begin
			top = acc[mtop];
			acc = ((acc << 1) & mask) ^ (top ? poly : '0) ^ (digit[j] ? x_q : '0);
		end
	end

	assign done = busy_q && (dig_q == '0);
	assign prod = acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dig_q  <= '0;
		end else if (!busy_q && go) begin
			busy_q <= 1'b1;
			dig_q  <= bfau_pkg::DIG_IDX_W'(mtop >> bfau_pkg::DIGIT_SH);
		end else if (busy_q) begin
			if (dig_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				dig_q <= dig_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && go) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc;
		end
	end

endmodule

>>> src/bfau_dp.sv
`timescale 1ns / 1ps

// Datapath: config registers, operand and working registers, multiplier,
// output register.
module bfau_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bfau_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bfau_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [bfau_pkg::ELEM_W-1:0]          in_a,
	input  logic [bfau_pkg::ELEM_W-1:0]          in_b,
	input  bfau_pkg::dp_cmd_t                    cmd,
	output bfau_pkg::dp_sts_t                    sts,
	output logic [bfau_pkg::ELEM_W-1:0]          out_value,
	output logic                                 out_err
);

	logic [bfau_pkg::DEG_W-1:0]   degree_q;
	logic [bfau_pkg::ELEM_W-1:0]  poly_q;
	logic [bfau_pkg::DEG_W-1:0]   eff_deg;
	logic [bfau_pkg::ELEM_W-1:0]  mask_d;

	logic [bfau_pkg::ELEM_W-1:0]  a_q;
	logic [bfau_pkg::ELEM_W-1:0]  b_q;
	logic [bfau_pkg::ELEM_W-1:0]  g_q;
	logic [bfau_pkg::ELEM_W-1:0]  t_q;
	logic [bfau_pkg::ELEM_W-1:0]  mask_q;
	logic [bfau_pkg::ELEM_W-1:0]  ipoly_q;
	logic [bfau_pkg::DEG_W-1:0]   deg_q;
	logic [bfau_pkg::MIDX_W-1:0]  mtop_q;
	logic [bfau_pkg::ELEM_W-1:0]  out_value_q;
	logic                         out_err_q;

	logic [bfau_pkg::ELEM_W-1:0]  base;
	logic [bfau_pkg::ELEM_W-1:0]  mul_x;
	logic [bfau_pkg::ELEM_W-1:0]  mul_y;
	logic [bfau_pkg::ELEM_W-1:0]  mul_p;
	logic                         mul_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= bfau_pkg::DEGREE_RESET;
			poly_q   <= bfau_pkg::POLY_RESET;
		end else if (cfg_we) begin
			case (bfau_pkg::cfg_reg_t'(cfg_index))
				bfau_pkg::REG_FIELD_DEGREE:   degree_q <= cfg_data[bfau_pkg::DEG_W-1:0];
				bfau_pkg::REG_REDUCTION_POLY: poly_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// degree clamped to 1..cap
	always_comb begin
		if (degree_q == '0) begin
			eff_deg = bfau_pkg::DEG_W'(1);
		end else if (degree_q > bfau_pkg::DEG_CAP) begin
			eff_deg = bfau_pkg::DEG_CAP;
		end else begin
			eff_deg = degree_q;
		end
		mask_d = {bfau_pkg::ELEM_W{1'b1}} >> (bfau_pkg::DEG_W'(bfau_pkg::ELEM_W) - eff_deg);
	end

	// per-item snapshot of operands and field shape
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= in_a & mask_d;
			b_q     <= in_b & mask_d;
			mask_q  <= mask_d;
			ipoly_q <= poly_q & mask_d;
			deg_q   <= eff_deg;
			mtop_q  <= bfau_pkg::MIDX_W'(eff_deg - bfau_pkg::DEG_W'(1));
		end
	end

	assign base = cmd.base_b ? b_q : a_q;

	always_ff @(posedge clk) begin
		if (cmd.g_load) begin
			g_q <= base;
		end
		case (cmd.t_src)
			bfau_pkg::T_HOLD: t_q <= t_q;
			bfau_pkg::T_XOR:  t_q <= a_q ^ b_q;
			bfau_pkg::T_ZERO: t_q <= '0;
			bfau_pkg::T_BASE: t_q <= base;
			bfau_pkg::T_B:    t_q <= b_q;
			bfau_pkg::T_PROD: t_q <= mul_p;
			default:          t_q <= t_q;
		endcase
		if (cmd.out_load) begin
			out_value_q <= t_q;
			out_err_q   <= cmd.out_err;
		end
	end

	always_comb begin
		case (cmd.mul_src)
			bfau_pkg::MS_TT: begin
				mul_x = t_q;
				mul_y = t_q;
			end
			bfau_pkg::MS_TG: begin
				mul_x = t_q;
				mul_y = g_q;
			end
			bfau_pkg::MS_AT: begin
				mul_x = a_q;
				mul_y = t_q;
			end
			default: begin
				mul_x = t_q;
				mul_y = t_q;
			end
		endcase
	end

	bfau_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.x      (mul_x),
		.y      (mul_y),
		.mask   (mask_q),
		.poly   (ipoly_q),
		.mtop   (mtop_q),
		.done   (mul_done),
		.prod   (mul_p)
	);

	assign sts.a_zero   = (a_q == '0);
	assign sts.b_zero   = (b_q == '0);
	assign sts.mul_done = mul_done;
	assign sts.degree   = deg_q;

	assign out_value = out_value_q;
	assign out_err   = out_err_q;

endmodule

>>> src/bfau_ctrl.sv
`timescale 1ns / 1ps

// Controller: sequences decode, square-and-multiply loop, final product and
// the output slot.
module bfau_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bfau_pkg::OP_W-1:0]       op_in,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  bfau_pkg::dp_sts_t               sts,
	output bfau_pkg::dp_cmd_t               cmd
);

	bfau_pkg::state_t              state_q;
	bfau_pkg::state_t              state_d;
	bfau_pkg::op_t                 op_q;
	logic [bfau_pkg::DEG_W-1:0]    cnt_q;
	logic                          err_q;
	logic                          out_valid_q;
	logic                          base_zero;
	logic                          short_loop;

	// inverse takes the first operand, divide inverts the second
	assign base_zero  = (op_q == bfau_pkg::OP_DIV) ? sts.b_zero : sts.a_zero;
	assign short_loop = (sts.degree <= bfau_pkg::DEG_W'(2));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfau_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = bfau_pkg::ST_DECODE;
				end
			end
			bfau_pkg::ST_DECODE: begin
				case (op_q)
					bfau_pkg::OP_MUL: state_d = bfau_pkg::ST_FIN_MUL;
					bfau_pkg::OP_DIV,
					bfau_pkg::OP_INV: begin
						if (base_zero) begin
							state_d = bfau_pkg::ST_WRITE;
						end else if (short_loop) begin
							state_d = bfau_pkg::ST_LAST_SQ;
						end else begin
							state_d = bfau_pkg::ST_LOOP_SQ;
						end
					end
					default: state_d = bfau_pkg::ST_WRITE;
				endcase
			end
			bfau_pkg::ST_LOOP_SQ: begin
				if (sts.mul_done) begin
					state_d = bfau_pkg::ST_LOOP_MG;
				end
			end
			bfau_pkg::ST_LOOP_MG: begin
				if (sts.mul_done) begin
					state_d = (cnt_q == bfau_pkg::DEG_W'(1)) ? bfau_pkg::ST_LAST_SQ
					                                          : bfau_pkg::ST_LOOP_SQ;
				end
			end
			bfau_pkg::ST_LAST_SQ: begin
				if (sts.mul_done) begin
					state_d = (op_q == bfau_pkg::OP_DIV) ? bfau_pkg::ST_FIN_MUL
					                                     : bfau_pkg::ST_WRITE;
				end
			end
			bfau_pkg::ST_FIN_MUL: begin
				if (sts.mul_done) begin
					state_d = bfau_pkg::ST_WRITE;
				end
			end
			bfau_pkg::ST_WRITE: begin
				if (!out_valid_q || m_tready) begin
					state_d = bfau_pkg::ST_IDLE;
				end
			end
			default: state_d = bfau_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.t_src    = bfau_pkg::T_HOLD;
		cmd.mul_src  = bfau_pkg::MS_TT;
		cmd.out_err  = err_q;
		case (state_q)
			bfau_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			bfau_pkg::ST_DECODE: begin
				case (op_q)
					bfau_pkg::OP_ADD,
					bfau_pkg::OP_SUB: cmd.t_src = bfau_pkg::T_XOR;
					bfau_pkg::OP_MUL: cmd.t_src = bfau_pkg::T_B;
					bfau_pkg::OP_DIV,
					bfau_pkg::OP_INV: begin
						cmd.base_b = (op_q == bfau_pkg::OP_DIV);
						cmd.g_load = 1'b1;
						cmd.t_src  = base_zero ? bfau_pkg::T_ZERO : bfau_pkg::T_BASE;
					end
					default: cmd.t_src = bfau_pkg::T_ZERO;
				endcase
			end
			bfau_pkg::ST_LOOP_SQ,
			bfau_pkg::ST_LAST_SQ: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_src = bfau_pkg::MS_TT;
				cmd.t_src   = sts.mul_done ? bfau_pkg::T_PROD : bfau_pkg::T_HOLD;
			end
			bfau_pkg::ST_LOOP_MG: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_src = bfau_pkg::MS_TG;
				cmd.t_src   = sts.mul_done ? bfau_pkg::T_PROD : bfau_pkg::T_HOLD;
			end
			bfau_pkg::ST_FIN_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_src = bfau_pkg::MS_AT;
				cmd.t_src   = sts.mul_done ? bfau_pkg::T_PROD : bfau_pkg::T_HOLD;
			end
			bfau_pkg::ST_WRITE: begin
				cmd.out_load = !out_valid_q || m_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfau_pkg::ST_IDLE;
			op_q        <= bfau_pkg::OP_ADD;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= bfau_pkg::op_t'(op_in);
			end
			if (state_q == bfau_pkg::ST_DECODE) begin
				err_q <= ((op_q == bfau_pkg::OP_DIV) || (op_q == bfau_pkg::OP_INV)) && base_zero;
				cnt_q <= short_loop ? '0 : sts.degree - bfau_pkg::DEG_W'(2);
			end else if (state_q == bfau_pkg::ST_LOOP_MG && sts.mul_done) begin
				cnt_q <= cnt_q - bfau_pkg::DEG_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == bfau_pkg::ST_DECODE))
		else $error("accepted beat did not move to decode");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfau_pkg::ST_LOOP_SQ || state_q == bfau_pkg::ST_LOOP_MG) |-> (cnt_q != '0))
		else $error("exponent loop running with zero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == bfau_pkg::ST_LOOP_SQ || state_q == bfau_pkg::ST_LOOP_MG ||
		                  state_q == bfau_pkg::ST_LAST_SQ || state_q == bfau_pkg::ST_FIN_MUL))
		else $error("multiplier finished outside a multiply state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfau_pkg::ST_DECODE && op_q == bfau_pkg::OP_INV && sts.a_zero) |=> err_q)
		else $error("inverse of zero not flagged");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

	// op codes the unit does not define; they must return 0 with no error
	localparam logic [bfau_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [bfau_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [bfau_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

	localparam int RANDOM_PHASES   = 12;
	localparam int BEATS_PER_PHASE = 100;
	localparam int TAIL_CYCLES     = 400;   // longer than a 32-bit divide

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_GAPS,
		PACE_SINK_STALLS,
		PACE_BOTH
	} pace_t;

	typedef struct {
		logic [bfau_pkg::ELEM_W-1:0] value;
		logic                        zdiv;
	} field_result_t;

	// directed vector: op, a, b, then a hand-typed answer where typed is set
	typedef struct packed {
		logic [bfau_pkg::OP_W-1:0]   op;
		logic [bfau_pkg::ELEM_W-1:0] a;
		logic [bfau_pkg::ELEM_W-1:0] b;
		logic                        typed;
		logic [bfau_pkg::ELEM_W-1:0] value;
		logic                        zdiv;
	} vector_t;

	localparam int NUM_VECTORS = 23;

	// all rows run at the reset field: m = 8, x^8+x^4+x^3+x^2+1
	localparam vector_t DIRECTED_VECTORS [NUM_VECTORS] = '{
		'{bfau_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h00, 1'b0},
		'{bfau_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFF, 1'b0}, // high bits
		'{bfau_pkg::OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h00, 1'b0},
		'{bfau_pkg::OP_SUB, 32'h0000_005A, 32'h0000_00FF, 1'b1, 32'hA5, 1'b0},
		'{bfau_pkg::OP_MUL, 32'h0000_0080, 32'h0000_0002, 1'b1, 32'h1D, 1'b0}, // one fold
		'{bfau_pkg::OP_MUL, 32'h0000_00FF, 32'h0000_00FF, 1'b0, 32'h00, 1'b0},
		'{bfau_pkg::OP_MUL, 32'hFFFF_FF00, 32'h0000_0037, 1'b1, 32'h00, 1'b0}, // a masks to 0
		'{bfau_pkg::OP_MUL, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'hFF, 1'b0},
		'{bfau_pkg::OP_DIV, 32'h0000_0053, 32'h0000_0000, 1'b1, 32'h00, 1'b1}, // zero divisor
		'{bfau_pkg::OP_DIV, 32'h0000_0012, 32'hFFFF_FF00, 1'b1, 32'h00, 1'b1}, // b masks to 0
		'{bfau_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0002, 1'b1, 32'h8E, 1'b0},
		'{bfau_pkg::OP_DIV, 32'h0000_00FF, 32'h0000_00FF, 1'b1, 32'h01, 1'b0},
		'{bfau_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0035, 1'b1, 32'h00, 1'b0},
		'{bfau_pkg::OP_INV, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h00, 1'b1}, // inverse of 0
		'{bfau_pkg::OP_INV, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h01, 1'b0},
		'{bfau_pkg::OP_INV, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 32'h8E, 1'b0}, // b ignored
		'{bfau_pkg::OP_INV, 32'h0000_00FF, 32'h0000_0000, 1'b0, 32'h00, 1'b0},
		'{bfau_pkg::OP_INV, 32'hFFFF_FF00, 32'h0000_0000, 1'b1, 32'h00, 1'b1},
		'{OP_SPARE5,        32'h0000_00FF, 32'h0000_00FF, 1'b1, 32'h00, 1'b0},
		'{OP_SPARE6,        32'h0000_0012, 32'h0000_0034, 1'b1, 32'h00, 1'b0},
		'{OP_SPARE7,        32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h00, 1'b0},
		'{bfau_pkg::OP_DIV, 32'h0000_00C3, 32'h0000_007F, 1'b0, 32'h00, 1'b0},
		'{bfau_pkg::OP_MUL, 32'h0000_00A5, 32'h0000_005A, 1'b0, 32'h00, 1'b0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bfau_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bfau_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [2*bfau_pkg::ELEM_W-1:0]   s_tdata;     // [31:0] operand_a, [63:32] operand_b
	logic [bfau_pkg::OP_W-1:0]       s_tuser;     // [2:0] operation
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [bfau_pkg::ELEM_W-1:0]     m_tdata;     // [31:0] result_value
	logic                            m_tuser;     // [0] zero_divisor_error

	// local copy of the field settings, tracked on every register write
	logic [bfau_pkg::DEG_W-1:0]      degree_setting;
	logic [bfau_pkg::ELEM_W-1:0]     modulus_setting;

	pace_t                           pace;
	field_result_t                   pending_results [$];
	int                              mismatches;
	int                              beats_in;
	int                              beats_out;
	int                              zdiv_seen;
	int                              settings_used;

	binary_field_arithmetic_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- field math

	// degree codes 0 and above the cap fold onto the nearest legal degree
	function automatic int active_degree();
		int m;
		m = int'(degree_setting);
		if (m < 1)
			m = 1;
		if (m > int'(bfau_pkg::DEG_CAP))
			m = int'(bfau_pkg::DEG_CAP);
		return m;
	endfunction

	function automatic logic [bfau_pkg::ELEM_W-1:0] elem_mask(int m);
		return bfau_pkg::ELEM_W'((64'd1 << m) - 64'd1);
	endfunction

	// carry-less product, then fold bits m..2m-2 back with the modulus
	function automatic logic [bfau_pkg::ELEM_W-1:0] field_product(
		logic [bfau_pkg::ELEM_W-1:0] a, logic [bfau_pkg::ELEM_W-1:0] b, int m,
		logic [bfau_pkg::ELEM_W-1:0] poly);
		logic [63:0] p;
		p = '0;
		for (int i = 0; i < m; i++)
			if (b[i])
				p ^= {32'd0, a} << i;
		for (int k = 2 * m - 2; k >= m; k--)
			if (p[k])
				p ^= (64'd1 << k) ^ ({32'd0, poly} << (k - m));
		return p[bfau_pkg::ELEM_W-1:0] & elem_mask(m);
	endfunction

	// a^(2^m - 2), square-and-multiply from the low exponent bit
	function automatic logic [bfau_pkg::ELEM_W-1:0] field_inverse(
		logic [bfau_pkg::ELEM_W-1:0] a, int m, logic [bfau_pkg::ELEM_W-1:0] poly);
		logic [63:0]                 e;
		logic [bfau_pkg::ELEM_W-1:0] acc;
		logic [bfau_pkg::ELEM_W-1:0] sq;
		e   = (64'd1 << m) - 64'd2;
		acc = bfau_pkg::ELEM_W'(1);
		sq  = a;
		while (e != 0) begin
			if (e[0])
				acc = field_product(acc, sq, m, poly);
			sq = field_product(sq, sq, m, poly);
			e  = e >> 1;
		end
		return acc;
	endfunction

	function automatic field_result_t predict_field_op(logic [bfau_pkg::OP_W-1:0] op,
		logic [bfau_pkg::ELEM_W-1:0] a_in, logic [bfau_pkg::ELEM_W-1:0] b_in);
		field_result_t               r;
		int                          m;
		logic [bfau_pkg::ELEM_W-1:0] mask;
		logic [bfau_pkg::ELEM_W-1:0] poly;
		logic [bfau_pkg::ELEM_W-1:0] a;
		logic [bfau_pkg::ELEM_W-1:0] b;
		m       = active_degree();
		mask    = elem_mask(m);
		poly    = modulus_setting & mask;
		a       = a_in & mask;
		b       = b_in & mask;
		r.value = '0;
		r.zdiv  = 1'b0;
		case (op)
			bfau_pkg::OP_ADD, bfau_pkg::OP_SUB: begin
				r.value = a ^ b;
			end
			bfau_pkg::OP_MUL: begin
				r.value = field_product(a, b, m, poly);
			end
			bfau_pkg::OP_DIV: begin
				if (b == 0)
					r.zdiv = 1'b1;
				else
					r.value = field_product(a, field_inverse(b, m, poly), m, poly);
			end
			bfau_pkg::OP_INV: begin
				if (a == 0)
					r.zdiv = 1'b1;
				else
					r.value = field_inverse(a, m, poly);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- pacing

	function automatic bit src_gap();
		case (pace)
			PACE_SRC_GAPS: return $urandom_range(99) < 51;
			PACE_BOTH:     return $urandom_range(99) < 25;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic bit sink_stall();
		case (pace)
			PACE_SINK_STALLS: return $urandom_range(99) < 51;
			PACE_BOTH:        return $urandom_range(99) < 25;
			default:          return 1'b0;
		endcase
	endfunction

	// sink side: m_tready moves on the falling edge only
	always @(negedge clk)
		m_tready <= !sink_stall();

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, logic [bfau_pkg::ELEM_W-1:0] got,
		logic [bfau_pkg::ELEM_W-1:0] want);
		$display("[%0t] mismatch on %s, result beat %0d: got %h, want %h",
			$realtime, what, beats_out, got, want);
		mismatches++;
	endtask

	// result beats are taken at the rising edge, compared against the oldest
	// pending expectation
	always @(posedge clk) begin
		field_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value)
					report_mismatch("result_value", m_tdata, want.value);
				if (m_tuser !== want.zdiv)
					report_mismatch("zero_divisor_error", bfau_pkg::ELEM_W'(m_tuser),
						bfau_pkg::ELEM_W'(want.zdiv));
			end
			if (m_tuser === 1'b1)
				zdiv_seen++;
			beats_out++;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// entered and left just after a falling edge
	task automatic send_beat(logic [bfau_pkg::OP_W-1:0] op, logic [bfau_pkg::ELEM_W-1:0] a,
		logic [bfau_pkg::ELEM_W-1:0] b, logic typed,
		logic [bfau_pkg::ELEM_W-1:0] typed_value, logic typed_zdiv);
		field_result_t want;
		while (src_gap()) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {b, a};
		s_tuser  = op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (typed) begin
			want.value = typed_value;
			want.zdiv  = typed_zdiv;
		end else begin
			want = predict_field_op(op, a, b);
		end
		pending_results.push_back(want);
		beats_in++;
		@(negedge clk);
	endtask

	// waits until the unit is idle: every beat gives one result, so an
	// empty queue means nothing is in flight
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(bfau_pkg::cfg_reg_t idx, logic [bfau_pkg::CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == bfau_pkg::REG_FIELD_DEGREE)
			degree_setting = data[bfau_pkg::DEG_W-1:0];
		else
			modulus_setting = data;
	endtask

	// mixes the edge cases in: zero, one, all ones, and bits only above m
	function automatic logic [bfau_pkg::ELEM_W-1:0] pick_operand(int m);
		case ($urandom_range(15))
			0:       return '0;
			1:       return bfau_pkg::ELEM_W'(1);
			2:       return '1;
			3:       return (m >= bfau_pkg::ELEM_W) ? '0 : bfau_pkg::ELEM_W'($urandom) << m;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [bfau_pkg::OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return bfau_pkg::OP_ADD;
		if (r < 16)
			return bfau_pkg::OP_SUB;
		if (r < 40)
			return bfau_pkg::OP_MUL;
		if (r < 66)
			return bfau_pkg::OP_DIV;
		if (r < 92)
			return bfau_pkg::OP_INV;
		if (r < 95)
			return OP_SPARE5;
		if (r < 98)
			return OP_SPARE6;
		return OP_SPARE7;
	endfunction

	initial begin
		logic [bfau_pkg::DEG_W-1:0]  deg;
		logic [bfau_pkg::ELEM_W-1:0] poly;
		int                          m;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = bfau_pkg::REG_FIELD_DEGREE;
		cfg_data        = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = bfau_pkg::OP_ADD;
		pace            = PACE_FULL;
		degree_setting  = bfau_pkg::DEGREE_RESET;
		modulus_setting = bfau_pkg::POLY_RESET;
		mismatches      = 0;
		beats_in        = 0;
		beats_out       = 0;
		zdiv_seen       = 0;
		settings_used   = 1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed vectors at the reset field
		for (int i = 0; i < NUM_VECTORS; i++)
			send_beat(DIRECTED_VECTORS[i].op, DIRECTED_VECTORS[i].a,
				DIRECTED_VECTORS[i].b, DIRECTED_VECTORS[i].typed,
				DIRECTED_VECTORS[i].value, DIRECTED_VECTORS[i].zdiv);

		// random phases; the first six pin the degree extremes and known
		// irreducible moduli, the rest mostly small random fields
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case (ph)
				0: begin deg = 6'd1;  poly = $urandom;       end
				1: begin deg = 6'd32; poly = 32'h0000_008D;  end
				2: begin deg = 6'd0;  poly = 32'hFFFF_FFFF;  end  // folds to m = 1
				3: begin deg = 6'd63; poly = $urandom;       end  // folds to m = 32
				4: begin deg = 6'd2;  poly = 32'h0000_0003;  end
				5: begin deg = 6'd16; poly = 32'h0000_100B;  end
				default: begin
					if ($urandom_range(5) == 0)
						deg = bfau_pkg::DEG_W'($urandom_range(63));
					else
						deg = bfau_pkg::DEG_W'($urandom_range(12, 1));
					poly = $urandom;                              // often reducible
				end
			endcase
			pace = pace_t'(ph % 4);
			write_reg(bfau_pkg::REG_FIELD_DEGREE, bfau_pkg::CFG_DATA_W'(deg));
			write_reg(bfau_pkg::REG_REDUCTION_POLY, poly);
			settings_used++;
			m = active_degree();
			for (int n = 0; n < BEATS_PER_PHASE; n++)
				send_beat(pick_op(), pick_operand(m), pick_operand(m), 1'b0, '0, 1'b0);
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d operation beats (%0d results, %0d zero-divisor flags)",
			beats_in, beats_out, zdiv_seen);
		$display("over %0d field settings, degree 1..32 plus folded degree codes 0 and 63",
			settings_used);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
src/bfau_pkg.sv
src/bfau_mul.sv
src/bfau_dp.sv
src/bfau_ctrl.sv
src/binary_field_arithmetic_unit.sv
bench/tb.sv
